// ===== hw/rtl/modexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register indexes and the interface structs between the
// sequencer and the modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int OPW       = 16;
	localparam int EXP_BITS  = 16;
	localparam int OPW_CNT_W = $clog2(OPW);
	localparam int EXP_CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENCRYPT_EXP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_EXP = 2'd2;

	localparam logic [OPW-1:0] MODULUS_RST     = 16'd20131;
	localparam logic [OPW-1:0] ENCRYPT_EXP_RST = 16'd2997;
	localparam logic [OPW-1:0] DECRYPT_EXP_RST = 16'd10333;

	typedef struct packed {
		logic           start;
		logic [OPW-1:0] a;
		logic [OPW-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic           done;
		logic [OPW-1:0] prod;
	} mm_rsp_t;

endpackage

// ===== hw/rtl/modexp_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular multiplier
// Interleaved shift-add multiplier that computes a * b mod m, scanning b from
// its most significant bit, one bit per cycle. Requires a below m.
// ----------------------------------------------------------------------------
module modexp_modmul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [modexp_pkg::OPW-1:0]  modulus,
	input  modexp_pkg::mm_req_t         req,
	output modexp_pkg::mm_rsp_t         rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [modexp_pkg::OPW_CNT_W-1:0] cnt_q;
	logic [modexp_pkg::OPW-1:0]       a_q;
	logic [modexp_pkg::OPW-1:0]       b_q;
	logic [modexp_pkg::OPW-1:0]       r_q;

	logic [modexp_pkg::OPW:0] m_ext;
	logic [modexp_pkg::OPW:0] dbl;
	logic [modexp_pkg::OPW:0] dbl_red;
	logic [modexp_pkg::OPW:0] sum;
	logic [modexp_pkg::OPW:0] sum_red;

	always_comb begin
		m_ext   = {1'b0, modulus};
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
		sum     = {1'b0, dbl_red[modexp_pkg::OPW-1:0]}
			+ (b_q[modexp_pkg::OPW-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == modexp_pkg::OPW_CNT_W'(modexp_pkg::OPW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= sum_red[modexp_pkg::OPW-1:0];
			b_q <= {b_q[modexp_pkg::OPW-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = r_q;

endmodule

// ===== hw/rtl/modexp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square-and-multiply sequencer
// Reduces the base, then scans the exponent from its lowest bit, issuing the
// accumulator multiply and the squaring to the shared modular multiplier.
// ----------------------------------------------------------------------------
module modexp_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [modexp_pkg::OPW-1:0]  in_base,
	input  logic [modexp_pkg::OPW-1:0]  in_expo,
	output modexp_pkg::mm_req_t         mm_req,
	input  modexp_pkg::mm_rsp_t         mm_rsp,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [modexp_pkg::OPW-1:0]  res_value
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RED  = 5'b00010,
		ST_STEP = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_SQR  = 5'b10000
	} state_t;

	localparam logic [modexp_pkg::OPW-1:0] ONE = modexp_pkg::OPW'(1);

	state_t                           state_q;
	logic                             fin_q;
	logic [modexp_pkg::EXP_CNT_W-1:0] bit_cnt_q;
	logic [modexp_pkg::EXP_BITS-1:0]  exp_q;
	logic [modexp_pkg::OPW-1:0]       acc_q;
	logic [modexp_pkg::OPW-1:0]       sq_q;
	logic                             last_bit;

	assign in_ready  = (state_q == ST_IDLE) && !fin_q;
	assign res_valid = fin_q;
	assign res_value = acc_q;
	assign last_bit  = bit_cnt_q == modexp_pkg::EXP_CNT_W'(modexp_pkg::EXP_BITS - 1);

	always_comb begin
		mm_req.start = 1'b0;
		mm_req.a     = sq_q;
		mm_req.b     = sq_q;
		case (state_q)
			ST_IDLE: begin
				mm_req.start = in_valid && in_ready;
				mm_req.a     = ONE;
				mm_req.b     = in_base;
			end
			ST_STEP: begin
				mm_req.start = 1'b1;
				if (exp_q[0]) begin
					mm_req.a = acc_q;
				end
			end
			ST_MUL: begin
				mm_req.start = mm_rsp.done;
			end
			default: begin
				mm_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fin_q     <= 1'b0;
			bit_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (fin_q && res_ready) begin
						fin_q <= 1'b0;
					end else if (in_valid && in_ready) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					if (mm_rsp.done) begin
						bit_cnt_q <= '0;
						state_q   <= ST_STEP;
					end
				end
				ST_STEP: begin
					state_q <= exp_q[0] ? ST_MUL : ST_SQR;
				end
				ST_MUL: begin
					if (mm_rsp.done) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (mm_rsp.done) begin
						bit_cnt_q <= bit_cnt_q + 1'b1;
						if (last_bit) begin
							fin_q   <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_STEP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					exp_q <= modexp_pkg::EXP_BITS'(in_expo);
				end
			end
			ST_RED: begin
				if (mm_rsp.done) begin
					sq_q  <= mm_rsp.prod;
					acc_q <= ONE;
				end
			end
			ST_MUL: begin
				if (mm_rsp.done) begin
					acc_q <= mm_rsp.prod;
				end
			end
			ST_SQR: begin
				if (mm_rsp.done) begin
					sq_q  <= mm_rsp.prod;
					exp_q <= exp_q >> 1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/modular_exponentiation_top.sv =====
`timescale 1ns / 1ps
// One item is in work at a time, and each modular multiply runs in the shared bit-serial multiplier.
// A result waits in the output register while the next item is accepted.
// Reset is asynchronous, active low; it loads modulus 20131 and exponents
// 2997 and 10333 and leaves the block idle and empty.
// ----------------------------------------------------------------------------
// Modular exponentiation engine
// Right-to-left binary square-and-multiply over a configured 16-bit modulus.
// ----------------------------------------------------------------------------
module modular_exponentiation_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [15:0]                           s_tdata,   // [15:0] base_value
	input  logic                                  s_tuser,   // [0] operation
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [15:0]                           m_tdata,   // [15:0] result_value
	input  logic                                  cfg_wen,
	input  logic [modexp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [15:0]                           cfg_wdata
);

	logic [modexp_pkg::OPW-1:0] modulus_q;
	logic [modexp_pkg::OPW-1:0] enc_exp_q;
	logic [modexp_pkg::OPW-1:0] dec_exp_q;
	logic                       out_valid_q;
	logic [modexp_pkg::OPW-1:0] out_data_q;

	modexp_pkg::mm_req_t        mm_req;
	modexp_pkg::mm_rsp_t        mm_rsp;
	logic                       res_valid;
	logic                       res_ready;
	logic [modexp_pkg::OPW-1:0] res_value;
	logic [modexp_pkg::OPW-1:0] sel_expo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= modexp_pkg::MODULUS_RST;
			enc_exp_q <= modexp_pkg::ENCRYPT_EXP_RST;
			dec_exp_q <= modexp_pkg::DECRYPT_EXP_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				modexp_pkg::REG_MODULUS:     modulus_q <= cfg_wdata;
				modexp_pkg::REG_ENCRYPT_EXP: enc_exp_q <= cfg_wdata;
				modexp_pkg::REG_DECRYPT_EXP: dec_exp_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign sel_expo = s_tuser ? dec_exp_q : enc_exp_q;

	modexp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (modulus_q),
		.req     (mm_req),
		.rsp     (mm_rsp)
	);

	modexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_base   (s_tdata),
		.in_expo   (sel_expo),
		.mm_req    (mm_req),
		.mm_rsp    (mm_rsp),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_value (res_value)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	// A modulus of zero or one always yields zero.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= (modulus_q <= modexp_pkg::OPW'(1)) ? '0 : res_value;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	a_mult_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mm_rsp.done |-> !s_tready)
		else $error("multiplier finished while the sequencer was idle");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (modulus_q > 16'd1) |-> m_tdata < modulus_q)
		else $error("result not reduced below the modulus");
`endif

endmodule
